// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL; ircl_core is the module that includes them.
// Each use expects i_clk and i_rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_CLK(label, !(cond), msg)

`endif

// ===== rtl/ircl_pkg.sv =====
// Shared constants and types for the IR distance calibration lookup block.
// No dependencies; imported by every other RTL file but assert_macros.svh.
package ircl_pkg;

    localparam int SEGMENTS    = 16;
    localparam int TABLE_DEPTH = 256;
    localparam int PPS_MAX     = 16;
    localparam int PPS_RESET   = 9;

    localparam int ADC_W  = 16;
    localparam int IDX_W  = 4;
    localparam int PPS_W  = 5;
    localparam int POS_W  = 8;
    localparam int SEG_W  = $clog2(SEGMENTS);
    localparam int TBL_AW = $clog2(TABLE_DEPTH);
    localparam int LEN_W  = TBL_AW + 1;
    localparam int DIV_CW = $clog2(ADC_W);

    localparam logic MODE_STORE  = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef struct packed {
        logic             mode;
        logic             channel;
        logic [IDX_W-1:0] cal_index;
        logic [ADC_W-1:0] adc_value;
    } t_item;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } t_result;

endpackage

// ===== rtl/ircl_ifs.sv =====
// Valid/ready channel interfaces for input items and result items.
// Depends on ircl_pkg for field widths.
interface ircl_item_if import ircl_pkg::*;;
    logic             valid;
    logic             ready;
    logic             mode;
    logic             channel;
    logic [IDX_W-1:0] cal_index;
    logic [ADC_W-1:0] adc_value;

    modport source (output valid, mode, channel, cal_index, adc_value, input ready);
    modport sink   (input valid, mode, channel, cal_index, adc_value, output ready);
endinterface

interface ircl_res_if import ircl_pkg::*;;
    logic             valid;
    logic             ready;
    logic             found;
    logic [POS_W-1:0] position;

    modport source (output valid, found, position, input ready);
    modport sink   (input valid, found, position, output ready);
endinterface

// ===== rtl/ir_distance_calibration_lookup_top.sv =====
// Top level of the two-channel IR distance calibration lookup.
// Depends on ircl_pkg, ircl_ifs and ircl_core.
//
// Usage:
//   i_item (valid/ready): one beat per item. mode 0 stores adc_value as
//   calibration point cal_index of the channel; storing the last point
//   rebuilds that channel's interpolated table. mode 1 searches the built
//   table for the first entry equal to adc_value.
//   o_res (valid/ready): exactly one beat per item (found, position); stores
//   and misses return 0, 0.
//   i_cfg_wr_en/i_cfg_wr_data: points per segment, written while idle;
//   0 acts as 1 and values above 16 act as 16.
// Timing: a rebuild runs one bit-serial divide per segment and then writes
//   the table one entry per cycle; a lookup reads the table one entry per
//   cycle until a hit or the end of the built table.
//   Items are handled one at a time; the output register lets the next item
//   enter while the previous result still waits.
// Reset: input ready is low; tables are marked unbuilt, points per segment
//   returns to 9; memory contents are not cleared (no clearing pass).
// Stall: a held result in the output register lets one more item run; the
//   core then waits in its result state, input ready low, until it drains.
module ir_distance_calibration_lookup_top import ircl_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [PPS_W-1:0] i_cfg_wr_data,
    ircl_item_if.sink        i_item,
    ircl_res_if.source       o_res
);

    logic [PPS_W-1:0] r_pps;
    logic [PPS_W-1:0] pps_eff;

    t_item            item;
    logic             core_res_valid;
    logic             core_res_ready;
    t_result          core_res;

    logic             r_out_valid;
    t_result          r_out;

    // config register, clamped to the meaningful range
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pps <= PPS_W'(PPS_RESET);
        end else if (i_cfg_wr_en) begin
            r_pps <= i_cfg_wr_data;
        end
    end

    always_comb begin
        if (r_pps == '0) begin
            pps_eff = PPS_W'(1);
        end else if (r_pps > PPS_W'(PPS_MAX)) begin
            pps_eff = PPS_W'(PPS_MAX);
        end else begin
            pps_eff = r_pps;
        end
    end

    assign item = '{mode:      i_item.mode,
                    channel:   i_item.channel,
                    cal_index: i_item.cal_index,
                    adc_value: i_item.adc_value};

    ircl_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pps        (pps_eff),
        .i_item_valid (i_item.valid),
        .o_item_ready (i_item.ready),
        .i_item       (item),
        .o_res_valid  (core_res_valid),
        .i_res_ready  (core_res_ready),
        .o_res        (core_res)
    );

    // output register: takes a new beat when empty or being drained
    assign core_res_ready = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_res_valid && core_res_ready) begin
            r_out_valid <= 1'b1;
            r_out       <= core_res;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.found    = r_out.found;
    assign o_res.position = r_out.position;

endmodule

// ===== rtl/ircl_div.sv =====
// Restoring divider, one quotient bit per cycle: segment span / points.
// Depends on ircl_pkg.
module ircl_div import ircl_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [ADC_W-1:0] i_dividend,
    input  logic [PPS_W-1:0] i_divisor,
    output logic             o_busy,
    output logic             o_done,
    output logic [ADC_W-1:0] o_quot,
    output logic [PPS_W-1:0] o_rem
);

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [ADC_W-1:0]  r_q;
    logic [PPS_W-1:0]  r_rem;
    logic [PPS_W-1:0]  r_den;

    logic [PPS_W:0]    trial;
    logic              q_bit;
    logic [PPS_W-1:0]  n_rem;

    always_comb begin
        trial = {r_rem, r_q[ADC_W-1]};
        if (trial >= {1'b0, r_den}) begin
            q_bit = 1'b1;
            n_rem = PPS_W'(trial - {1'b0, r_den});
        end else begin
            q_bit = 1'b0;
            n_rem = trial[PPS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_den  <= i_divisor;
            end else if (r_busy) begin
                r_q   <= {r_q[ADC_W-2:0], q_bit};
                r_rem <= n_rem;
                r_cnt <= r_cnt + DIV_CW'(1);
                if (r_cnt == DIV_CW'(ADC_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/ircl_core.sv =====
// Sequencer around the calibration point memory and the interpolated table memory.
// Depends on ircl_pkg, ircl_div and assert_macros.svh.
`include "assert_macros.svh"

module ircl_core import ircl_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [PPS_W-1:0] i_pps,
    input  logic             i_item_valid,
    output logic             o_item_ready,
    input  t_item            i_item,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output t_result          o_res
);

    typedef enum logic [2:0] {
        S_IDLE, S_RB_A, S_RB_B, S_RB_D, S_DIV, S_FILL, S_LOOK, S_RES
    } t_state;

    // memories: one entry per channel and point / per channel and table slot
    logic [ADC_W-1:0] r_cal_mem [2*SEGMENTS];
    logic [ADC_W-1:0] r_tbl_mem [2*TABLE_DEPTH];
    logic [ADC_W-1:0] r_cal_rdata;
    logic [ADC_W-1:0] r_tbl_rdata;

    logic              cal_we;
    logic [SEG_W:0]    cal_waddr;
    logic [SEG_W:0]    cal_raddr;
    logic              tbl_we;
    logic [TBL_AW:0]   tbl_waddr;
    logic [ADC_W-1:0]  tbl_wdata;
    logic [TBL_AW:0]   tbl_raddr;

    t_state            r_state, n_state;
    logic              r_ch, n_ch;
    logic [ADC_W-1:0]  r_val, n_val;
    logic [SEG_W-1:0]  r_seg, n_seg;
    logic [LEN_W-1:0]  r_n, n_n;
    logic [PPS_W-1:0]  r_j, n_j;
    logic [ADC_W-1:0]  r_a, n_a;
    logic              r_neg, n_neg;
    logic [ADC_W-1:0]  r_qd, n_qd;
    logic [PPS_W-1:0]  r_rd, n_rd;
    logic [ADC_W-1:0]  r_qacc, n_qacc;
    logic [PPS_W-1:0]  r_racc, n_racc;
    logic [LEN_W-1:0]  r_i, n_i;
    logic              r_pend, n_pend;
    logic [LEN_W-1:0]  r_pi, n_pi;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [1:0]        r_built, n_built;
    logic [LEN_W-1:0]  r_blen [2];
    logic [LEN_W-1:0]  n_blen [2];
    logic              r_found, n_found;
    logic [POS_W-1:0]  r_pos, n_pos;

    logic              div_start;
    logic              div_busy;
    logic              div_done;
    logic [ADC_W-1:0]  div_quot;
    logic [PPS_W-1:0]  div_rem;
    logic [ADC_W-1:0]  div_mag;

    logic              seg_last;
    logic              fill_last;
    logic [ADC_W-1:0]  pt_b;
    logic [PPS_W:0]    rsum;

    ircl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_mag),
        .i_divisor  (i_pps),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    assign seg_last  = (r_seg == SEG_W'(SEGMENTS - 1));
    assign fill_last = (r_j == i_pps - PPS_W'(1));

    always_comb begin
        n_state   = r_state;
        n_ch      = r_ch;
        n_val     = r_val;
        n_seg     = r_seg;
        n_n       = r_n;
        n_j       = r_j;
        n_a       = r_a;
        n_neg     = r_neg;
        n_qd      = r_qd;
        n_rd      = r_rd;
        n_qacc    = r_qacc;
        n_racc    = r_racc;
        n_i       = r_i;
        n_pend    = r_pend;
        n_pi      = r_pi;
        n_len     = r_len;
        n_built   = r_built;
        n_blen    = r_blen;
        n_found   = r_found;
        n_pos     = r_pos;
        cal_we    = 1'b0;
        cal_waddr = {i_item.channel, SEG_W'(i_item.cal_index)};
        cal_raddr = {r_ch, r_seg};
        tbl_we    = 1'b0;
        tbl_waddr = {r_ch, r_n[TBL_AW-1:0]};
        tbl_wdata = r_neg ? (r_a - r_qacc) : (r_a + r_qacc);
        tbl_raddr = {r_ch, r_i[TBL_AW-1:0]};
        div_start = 1'b0;
        pt_b      = seg_last ? r_a : r_cal_rdata;   // last segment stays flat
        div_mag   = (pt_b >= r_a) ? (pt_b - r_a) : (r_a - pt_b);
        rsum      = {1'b0, r_racc} + {1'b0, r_rd};

        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid && o_item_ready) begin
                    n_ch    = i_item.channel;
                    n_val   = i_item.adc_value;
                    n_found = 1'b0;
                    n_pos   = '0;
                    n_state = S_RES;
                    if (i_item.mode == MODE_STORE) begin
                        if (int'(i_item.cal_index) < SEGMENTS) begin
                            cal_we = 1'b1;
                            if (i_item.cal_index == IDX_W'(SEGMENTS - 1)) begin
                                n_seg   = '0;
                                n_n     = '0;
                                n_state = S_RB_A;
                            end
                        end
                    end else begin
                        n_len  = r_blen[i_item.channel];
                        n_i    = '0;
                        n_pend = 1'b0;
                        if (r_built[i_item.channel] && r_blen[i_item.channel] != '0) begin
                            n_state = S_LOOK;
                        end
                    end
                end
            end
            S_RB_A: begin
                n_state = S_RB_B;
            end
            S_RB_B: begin
                cal_raddr = {r_ch, r_seg + SEG_W'(1)};
                n_a       = r_cal_rdata;
                n_state   = S_RB_D;
            end
            S_RB_D: begin
                div_start = 1'b1;
                n_neg     = (pt_b < r_a);
                n_j       = '0;
                n_qacc    = '0;
                n_racc    = '0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_qd    = div_quot;
                    n_rd    = div_rem;
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                // entry j = a +/- floor(|b-a|*j/pps), built up by quotient and remainder steps
                if (r_n < LEN_W'(TABLE_DEPTH)) begin
                    tbl_we = 1'b1;
                    n_n    = r_n + LEN_W'(1);
                end
                if (rsum >= {1'b0, i_pps}) begin
                    n_racc = PPS_W'(rsum - {1'b0, i_pps});
                    n_qacc = r_qacc + r_qd + ADC_W'(1);
                end else begin
                    n_racc = rsum[PPS_W-1:0];
                    n_qacc = r_qacc + r_qd;
                end
                n_j = r_j + PPS_W'(1);
                if (fill_last) begin
                    if (seg_last) begin
                        n_built[r_ch] = 1'b1;
                        n_blen[r_ch]  = n_n;
                        n_state       = S_RES;
                    end else begin
                        n_seg   = r_seg + SEG_W'(1);
                        n_state = S_RB_A;
                    end
                end
            end
            S_LOOK: begin
                // one read issued and one compare made per cycle
                if (r_pend && r_tbl_rdata == r_val) begin
                    n_found = 1'b1;
                    n_pos   = r_pi[POS_W-1:0];
                    n_state = S_RES;
                end else if (r_i == r_len) begin
                    n_state = S_RES;
                end else begin
                    n_pend = 1'b1;
                    n_pi   = r_i;
                    n_i    = r_i + LEN_W'(1);
                end
            end
            S_RES: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_built   <= '0;
            r_blen[0] <= '0;
            r_blen[1] <= '0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
            r_val   <= n_val;
            r_seg   <= n_seg;
            r_n     <= n_n;
            r_j     <= n_j;
            r_a     <= n_a;
            r_neg   <= n_neg;
            r_qd    <= n_qd;
            r_rd    <= n_rd;
            r_qacc  <= n_qacc;
            r_racc  <= n_racc;
            r_i     <= n_i;
            r_pend  <= n_pend;
            r_pi    <= n_pi;
            r_len   <= n_len;
            r_built <= n_built;
            r_blen  <= n_blen;
            r_found <= n_found;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cal_we) begin
            r_cal_mem[cal_waddr] <= i_item.adc_value;
        end
        r_cal_rdata <= r_cal_mem[cal_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        r_tbl_rdata <= r_tbl_mem[tbl_raddr];
    end

    // no beat is taken while reset is held
    assign o_item_ready = i_rst_n && (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_RES);
    assign o_res        = '{found: r_found, position: r_pos};

    `ASSERT_CLK(a_hit_within_len, (r_state == S_RES && r_found) |-> (LEN_W'(r_pos) < r_len), "lookup hit beyond built length")
    `ASSERT_CLK(a_rebuild_marks_built, (r_state == S_FILL && fill_last && seg_last) |=> (r_built[r_ch] && r_blen[r_ch] != '0), "rebuild did not mark table built")
    `ASSERT_NEVER(a_div_restart, div_start && div_busy, "divider restarted while busy")

endmodule

// ===== sim/ir_distance_calibration_lookup_top_tb.sv =====
// Self-checking testbench for ir_distance_calibration_lookup_top: directed table, then random
// calibration loads and lookups checked beat by beat against a behavioral table predictor.
// Depends on rtl/ircl_pkg.sv, rtl/ircl_ifs.sv and the RTL of the block.
`timescale 1ns / 1ps

module ir_distance_calibration_lookup_top_tb;
    import ircl_pkg::*;

    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int MAX_GAP       = 13;
    localparam int LONG_HOLD     = 700;   // receiver hold-off, long enough to back up the input
    localparam int DRAIN_CYCLES  = 8;     // settle time before a register write
    localparam int TAIL_CYCLES   = 300;   // quiet window after the last result
    localparam int PHASE_ITEMS   = 180;
    localparam int REPORT_LIMIT  = 10;

    // Shapes of a random calibration curve.
    typedef enum int {
        CURVE_RANDOM,
        CURVE_RISING,
        CURVE_FALLING,
        CURVE_EXTREME,
        CURVE_FLAT
    } t_curve;

    typedef struct {
        t_item   item;
        bit      typed;   // expected result written in the row, not predicted
        t_result res;
    } t_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [PPS_W-1:0] i_cfg_wr_data;

    ircl_item_if item_bus ();
    ircl_res_if  res_bus ();

    ir_distance_calibration_lookup_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_item        (item_bus),
        .o_res         (res_bus)
    );

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the calibration points, the
    // interpolated tables and the points-per-segment register.
    // ------------------------------------------------------------------
    logic [ADC_W-1:0] cal_pts   [2][SEGMENTS];
    logic [15:0]      pts_set   [2];            // which points have been written
    logic [ADC_W-1:0] lin_tbl   [2][TABLE_DEPTH];
    bit               tbl_ready [2];
    int               tbl_len   [2];
    logic [PPS_W-1:0] pps_reg;

    t_result expected_res_q[$];
    t_row    directed_rows[$];

    int  err_cnt;
    int  cycle_cnt;
    bit  quiet_src;   // sender offers back to back
    bit  quiet_snk;   // receiver adds no random stalls
    bit  hold_req;    // ask the receiver for one long hold-off

    // Works out the result of one item and applies its side effects to the
    // predictor state. A store to the last point rebuilds the channel table.
    function automatic t_result predict_result(input t_item it);
        t_result r;
        int      eff_pps;
        int      n;
        int      a;
        int      b;
        int      q;
        int      ch;
        r  = '0;
        ch = it.channel;
        if (it.mode == MODE_STORE) begin
            cal_pts[ch][it.cal_index] = it.adc_value;
            pts_set[ch][it.cal_index] = 1'b1;
            if (it.cal_index == SEGMENTS - 1) begin
                eff_pps = (pps_reg == 0) ? 1 : (pps_reg > PPS_MAX) ? PPS_MAX : int'(pps_reg);
                n = 0;
                for (int seg = 0; seg < SEGMENTS; seg++) begin
                    a = int'(cal_pts[ch][seg]);
                    // last segment has no next point and stays flat
                    b = (seg + 1 < SEGMENTS) ? int'(cal_pts[ch][seg + 1]) : a;
                    for (int j = 0; j < eff_pps; j++) begin
                        q = ((b - a) * j) / eff_pps;   // signed, truncates toward zero
                        if (n < TABLE_DEPTH) begin
                            lin_tbl[ch][n] = ADC_W'(a + q);
                            n++;
                        end
                    end
                end
                tbl_len[ch]   = n;
                tbl_ready[ch] = 1'b1;
            end
        end else if (tbl_ready[ch]) begin
            for (int i = 0; i < tbl_len[ch]; i++) begin
                if (lin_tbl[ch][i] == it.adc_value) begin
                    r.found    = 1'b1;
                    r.position = POS_W'(i);
                    break;
                end
            end
        end
        return r;
    endfunction

    function automatic void add_row(input logic mode, input logic ch, input int idx,
                                    input int val, input bit typed, input logic found,
                                    input int pos);
        t_row row;
        row.item.mode      = mode;
        row.item.channel   = ch;
        row.item.cal_index = IDX_W'(idx);
        row.item.adc_value = ADC_W'(val);
        row.typed          = typed;
        row.res.found      = found;
        row.res.position   = POS_W'(pos);
        directed_rows.push_back(row);
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset and the cycle limit.
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender side. The item is held until the beat is taken; valid only
    // drops when the next item is delayed, so back-to-back beats never see
    // a low-then-high pair of assignments in one step.
    // ------------------------------------------------------------------
    task automatic send_item(input t_item it, input bit typed, input t_result typed_res);
        int      gap;
        t_result pred;
        gap = quiet_src ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_bus.valid     <= 1'b1;
        item_bus.mode      <= it.mode;
        item_bus.channel   <= it.channel;
        item_bus.cal_index <= it.cal_index;
        item_bus.adc_value <= it.adc_value;
        do @(posedge i_clk); while (!item_bus.ready);
        // beat taken at this edge; predictor always runs to keep its state in step
        pred = predict_result(it);
        expected_res_q.push_back(typed ? typed_res : pred);
    endtask

    // Drops valid and waits for every outstanding result, then lets the
    // block settle. The register is only touched after this.
    task automatic drain_block();
        item_bus.valid <= 1'b0;
        while (expected_res_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_pps(input logic [PPS_W-1:0] value);
        drain_block();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        pps_reg = value;
        i_cfg_wr_en <= 1'b0;
    endtask

    // Full calibration load of one channel: points 0..15 in order, so the
    // final store rebuilds the table from points that are all written.
    task automatic load_curve(input logic ch, input t_curve shape);
        t_item it;
        int    val;
        val = $urandom_range(0, 65535);
        for (int k = 0; k < SEGMENTS; k++) begin
            case (shape)
                CURVE_RISING: begin
                    val = (k == 0) ? $urandom_range(0, 8191) : val + $urandom_range(0, 4095);
                    if (val > 65535) val = 65535;
                end
                CURVE_FALLING: begin
                    val = (k == 0) ? $urandom_range(57344, 65535) : val - $urandom_range(0, 4095);
                    if (val < 0) val = 0;
                end
                CURVE_EXTREME: val = $urandom_range(0, 1) ? 65535 : 0;
                CURVE_FLAT: ;
                default: val = $urandom_range(0, 65535);
            endcase
            it.mode      = MODE_STORE;
            it.channel   = ch;
            it.cal_index = IDX_W'(k);
            it.adc_value = ADC_W'(val);
            send_item(it, 1'b0, '0);
        end
    endtask

    // One phase of random traffic: mostly lookups aimed at built entries,
    // with whole calibration loads and scattered single-point stores.
    task automatic run_random_phase(input int n_items);
        t_item it;
        int    sent;
        int    pick;
        int    ch;
        int    idx;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            ch   = $urandom_range(0, 1);
            if (pick < 18 || !tbl_ready[ch] && pick < 50) begin
                load_curve(ch[0], t_curve'($urandom_range(0, 4)));
                sent += SEGMENTS;
            end else begin
                if (pick < 28) begin
                    // stray store; the last point only once the channel is complete
                    idx = (pts_set[ch] == '1) ? $urandom_range(0, 15) : $urandom_range(0, 14);
                    it.mode      = MODE_STORE;
                    it.cal_index = IDX_W'(idx);
                    it.adc_value = ADC_W'($urandom_range(0, 65535));
                end else begin
                    it.mode      = MODE_LOOKUP;
                    it.cal_index = IDX_W'($urandom_range(0, 15));
                    pick = $urandom_range(0, 99);
                    if (tbl_ready[ch] && pick < 75) begin
                        it.adc_value = lin_tbl[ch][$urandom_range(0, tbl_len[ch] - 1)];
                        if (pick < 12) it.adc_value = it.adc_value + 1'b1;
                        else if (pick < 20) it.adc_value = it.adc_value - 1'b1;
                    end else if (pick < 85) begin
                        it.adc_value = $urandom_range(0, 1) ? '1 : '0;
                    end else begin
                        it.adc_value = ADC_W'($urandom_range(0, 65535));
                    end
                end
                it.channel = ch[0];
                send_item(it, 1'b0, '0);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random stalls per beat, plus one long hold-off on
    // request while the sender keeps offering.
    // ------------------------------------------------------------------
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = quiet_snk ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_req) begin
                hold_req = 1'b0;
                stall    = LONG_HOLD;
            end
            if (stall > 0) begin
                res_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_bus.valid && res_bus.ready));
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted beat against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (expected_res_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= REPORT_LIMIT)
                    $display("t=%0t unexpected result beat found=%0b position=%0d",
                             $time, res_bus.found, res_bus.position);
            end else begin
                want = expected_res_q.pop_front();
                if (res_bus.found !== want.found || res_bus.position !== want.position) begin
                    err_cnt++;
                    if (err_cnt <= REPORT_LIMIT)
                        $display("t=%0t result mismatch: expected found=%0b position=%0d, got found=%0b position=%0d",
                                 $time, want.found, want.position,
                                 res_bus.found, res_bus.position);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        logic [PPS_W-1:0] phase_pps [8];
        err_cnt   = 0;
        cycle_cnt = 0;
        quiet_src = 1'b0;
        quiet_snk = 1'b0;
        hold_req  = 1'b0;
        pps_reg   = PPS_W'(PPS_RESET);
        pts_set   = '{16'h0, 16'h0};
        tbl_ready = '{1'b0, 1'b0};
        tbl_len   = '{0, 0};

        i_rst_n            <= 1'b0;
        i_cfg_wr_en        <= 1'b0;
        i_cfg_wr_data      <= '0;
        item_bus.valid     <= 1'b0;
        item_bus.mode      <= MODE_STORE;
        item_bus.channel   <= 1'b0;
        item_bus.cal_index <= '0;
        item_bus.adc_value <= '0;
        res_bus.ready      <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, run at the reset value of points per segment.
        // Lookups before any build must miss.
        add_row(MODE_LOOKUP, 1'b0, 0, 16'h0000, 1'b1, 1'b0, 0);
        add_row(MODE_LOOKUP, 1'b1, 15, 16'hFFFF, 1'b1, 1'b0, 0);
        // Channel 0 curve: full-scale jump, a falling segment (negative
        // slope truncates toward zero), a flat run, and a flat last segment.
        add_row(MODE_STORE, 1'b0, 0,  16'h0000, 1'b1, 1'b0, 0);
        add_row(MODE_STORE, 1'b0, 1,  16'hFFFF, 1'b1, 1'b0, 0);
        add_row(MODE_STORE, 1'b0, 2,  16'h1000, 1'b1, 1'b0, 0);
        add_row(MODE_STORE, 1'b0, 3,  16'h1000, 1'b1, 1'b0, 0);
        add_row(MODE_STORE, 1'b0, 4,  16'h8000, 1'b1, 1'b0, 0);
        add_row(MODE_STORE, 1'b0, 5,  16'h7FFF, 1'b1, 1'b0, 0);
        for (int k = 6; k < 15; k++)
            add_row(MODE_STORE, 1'b0, k, 16'h2000 + k * 16'h0333, 1'b1, 1'b0, 0);
        add_row(MODE_STORE, 1'b0, 15, 16'h1234, 1'b1, 1'b0, 0);   // triggers the rebuild
        // First entry of the table is point 0 itself.
        add_row(MODE_LOOKUP, 1'b0, 0, 16'h0000, 1'b1, 1'b1, 0);
        add_row(MODE_LOOKUP, 1'b0, 0, 16'hFFFF, 1'b0, 1'b0, 0);
        add_row(MODE_LOOKUP, 1'b0, 0, 16'h1234, 1'b0, 1'b0, 0);
        add_row(MODE_LOOKUP, 1'b0, 0, 16'h0001, 1'b0, 1'b0, 0);
        // Channel 1 still unbuilt while channel 0 is.
        add_row(MODE_LOOKUP, 1'b1, 0, 16'h0000, 1'b1, 1'b0, 0);

        foreach (directed_rows[r])
            send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].res);

        // Random part: one register setting per phase, extremes included.
        // The drain in write_pps doubles as the sender pausing for all results.
        phase_pps = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd3, 5'd17, 5'd9, 5'd0};
        phase_pps[7] = PPS_W'($urandom_range(0, 31));
        foreach (phase_pps[p]) begin
            write_pps(phase_pps[p]);
            quiet_src = ($urandom_range(0, 3) == 0);
            quiet_snk = ($urandom_range(0, 3) == 0);
            // back up the block once: receiver holds while items keep coming
            if (p == 2) hold_req = 1'b1;
            run_random_phase(PHASE_ITEMS);
        end

        drain_block();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_cnt == 0 && expected_res_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
